>>> rtl/ubxdf_pkg.sv
// ubxdf_pkg: shared constants, types and helpers for the ubx frame deframer
// no dependencies; imported by every rtl module of the block, not by the two channel interfaces

package ubxdf_pkg;

	localparam int MAX_FRAME_DEF = 512;

	// sync, class and message codes
	localparam logic [7:0] UBX_SYNC1   = 8'hB5;
	localparam logic [7:0] UBX_SYNC2   = 8'h62;
	localparam logic [7:0] CLS_NAV     = 8'h01;
	localparam logic [7:0] ID_SOL      = 8'h06;
	localparam logic [7:0] ID_POSLLH   = 8'h02;
	localparam logic [7:0] ID_VELNED   = 8'h12;
	localparam logic [7:0] ID_TIMEUTC  = 8'h21;

	// frame byte positions kept for field extraction
	localparam int HDR_BYTES   = 6;   // sync, class, id, length
	localparam int LEN_EXTRA   = 8;   // header plus checksum
	localparam int FIELD_BASE  = 10;
	localparam int FIELD_BYTES = 28;  // frame bytes 10 to 37
	localparam int SATS_POS    = 53;
	localparam int TOTAL_W     = 17;  // 8 + 16-bit length

	// message kind carried from front to back
	localparam logic [1:0] KIND_SOL     = 2'd0;
	localparam logic [1:0] KIND_POSLLH  = 2'd1;
	localparam logic [1:0] KIND_VELNED  = 2'd2;
	localparam logic [1:0] KIND_TIMEUTC = 2'd3;

	// field identifiers
	localparam logic [4:0] FID_FIX     = 5'd0;
	localparam logic [4:0] FID_SATS    = 5'd1;
	localparam logic [4:0] FID_LON     = 5'd2;
	localparam logic [4:0] FID_LAT     = 5'd3;
	localparam logic [4:0] FID_HEIGHT  = 5'd4;
	localparam logic [4:0] FID_HACC    = 5'd5;
	localparam logic [4:0] FID_VELN    = 5'd6;
	localparam logic [4:0] FID_VELE    = 5'd7;
	localparam logic [4:0] FID_VELD    = 5'd8;
	localparam logic [4:0] FID_HEADING = 5'd9;
	localparam logic [4:0] FID_SACC    = 5'd10;
	localparam logic [4:0] FID_YEAR    = 5'd11;
	localparam logic [4:0] FID_MONTH   = 5'd12;
	localparam logic [4:0] FID_DAY     = 5'd13;
	localparam logic [4:0] FID_HOUR    = 5'd14;
	localparam logic [4:0] FID_MINUTE  = 5'd15;
	localparam logic [4:0] FID_SECOND  = 5'd16;

	typedef logic [FIELD_BYTES-1:0][7:0] field_bytes_t;

	typedef struct packed {
		logic [1:0]   kind;
		field_bytes_t fb;
		logic [7:0]   sats;
	} frame_rec_t;

	typedef struct packed {
		logic       valid;
		frame_rec_t rec;
	} rec_req_t;

	// little-endian word at a byte offset from FIELD_BASE
	function automatic logic [31:0] le32_at(field_bytes_t fb, int unsigned off);
		return {fb[off+3], fb[off+2], fb[off+1], fb[off]};
	endfunction

	function automatic logic signed [32:0] sext33(logic [31:0] v);
		return {v[31], v};
	endfunction

	function automatic logic signed [32:0] zext33(logic [31:0] v);
		return {1'b0, v};
	endfunction

endpackage

>>> rtl/ubxdf_byte_if.sv
// ubxdf_byte_if: valid/ready channel carrying one received byte per word
// no dependencies

interface ubxdf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

>>> rtl/ubxdf_field_if.sv
// ubxdf_field_if: valid/ready channel carrying one decoded navigation field per word
// no dependencies

interface ubxdf_field_if;
	logic               valid;
	logic               ready;
	logic [4:0]         field_id;
	logic signed [32:0] field_value;
	logic               last_field;

	modport source (output valid, output field_id, output field_value, output last_field,
		input ready);
	modport sink   (input valid, input field_id, input field_value, input last_field,
		output ready);
endinterface

>>> rtl/ubxdf_front.sv
// ubxdf_front: byte intake, sync hunt, length tracking, fletcher-8 sum and frame check
// depends on ubxdf_pkg and ubxdf_byte_if; hands checked frames to ubxdf_queue

module ubxdf_front import ubxdf_pkg::*; #(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ubxdf_byte_if.sink   stream,
	input  logic         q_full,
	output rec_req_t     push
);

	localparam int PW = $clog2(MAX_FRAME + 1);

	logic [PW-1:0]      pos_q, pos_d;
	logic [7:0]         sum_a_q, sum_b_q, sum_a_d, sum_b_d;
	logic [7:0]         prev_q;
	logic [7:0]         cls_q, id_q;
	logic [15:0]        len_q;
	field_bytes_t       fb_q, fb_d;
	logic [7:0]         sats_q, sats_d;

	logic               accept;
	logic [7:0]         b;
	logic [TOTAL_W-1:0] pos_x, pos_inc, total;
	logic               in_body, sum_en, frame_end, known, sum_ok;
	logic [1:0]         kind;

	assign stream.ready = !q_full;

	always_comb begin
		accept  = stream.valid && stream.ready;
		b       = stream.data_byte;
		pos_x   = TOTAL_W'(pos_q);
		pos_inc = pos_x + TOTAL_W'(1);
		total   = TOTAL_W'(LEN_EXTRA) + TOTAL_W'(len_q);
		in_body = pos_x >= TOTAL_W'(2);
		// the two checksum bytes stay out of the sum
		sum_en  = (pos_x < TOTAL_W'(HDR_BYTES)) || (pos_x + TOTAL_W'(2) < total);
		frame_end = in_body && (pos_x >= TOTAL_W'(HDR_BYTES)) && (pos_inc >= total);

		known = 1'b1;
		case (id_q)
			ID_SOL:     kind = KIND_SOL;
			ID_POSLLH:  kind = KIND_POSLLH;
			ID_VELNED:  kind = KIND_VELNED;
			ID_TIMEUTC: kind = KIND_TIMEUTC;
			default: begin
				kind  = KIND_SOL;
				known = 1'b0;
			end
		endcase
		if (cls_q != CLS_NAV)
			known = 1'b0;
		// current byte is ck_b, previous one ck_a
		sum_ok = (sum_a_q == prev_q) && (sum_b_q == b);

		for (int k = 0; k < FIELD_BYTES; k++) begin
			fb_d[k] = (pos_x == TOTAL_W'(FIELD_BASE + k)) ? b : fb_q[k];
		end
		sats_d = (pos_x == TOTAL_W'(SATS_POS)) ? b : sats_q;

		sum_a_d = sum_a_q + b;
		sum_b_d = sum_b_q + sum_a_q + b;

		if (pos_x == TOTAL_W'(0)) begin
			pos_d = (b == UBX_SYNC1) ? PW'(1) : PW'(0);
		end else if (pos_x == TOTAL_W'(1)) begin
			pos_d = (b == UBX_SYNC2) ? PW'(2) : PW'(0);
		end else if (frame_end || pos_inc >= TOTAL_W'(MAX_FRAME)) begin
			pos_d = PW'(0);
		end else begin
			pos_d = pos_inc[PW-1:0];
		end

		push.valid    = accept && frame_end && known && sum_ok;
		push.rec.kind = kind;
		push.rec.fb   = fb_d;
		push.rec.sats = sats_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
			prev_q  <= '0;
			cls_q   <= '0;
			id_q    <= '0;
			len_q   <= '0;
			fb_q    <= '0;
			sats_q  <= '0;
		end else if (accept) begin
			pos_q <= pos_d;
			if (pos_x == TOTAL_W'(0) && b == UBX_SYNC1) begin
				sum_a_q <= '0;
				sum_b_q <= '0;
			end
			if (in_body) begin
				prev_q <= b;
				fb_q   <= fb_d;
				sats_q <= sats_d;
				if (sum_en) begin
					sum_a_q <= sum_a_d;
					sum_b_q <= sum_b_d;
				end
				if (pos_x == TOTAL_W'(2))
					cls_q <= b;
				if (pos_x == TOTAL_W'(3))
					id_q <= b;
				if (pos_x == TOTAL_W'(4))
					len_q[7:0] <= b;
				if (pos_x == TOTAL_W'(5))
					len_q[15:8] <= b;
			end
		end
	end

endmodule

>>> rtl/ubxdf_queue.sv
// ubxdf_queue: two-entry frame record queue between front and back
// depends on ubxdf_pkg

module ubxdf_queue import ubxdf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  rec_req_t push,
	input  logic     pop,
	output logic     full,
	output rec_req_t head
);

	frame_rec_t mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_pop;

	assign full       = cnt_q == 2'd2;
	assign head.valid = cnt_q != 2'd0;
	assign head.rec   = mem_q[rd_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.valid)
			mem_q[wr_q] <= push.rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push.valid)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push.valid) - 2'(do_pop);
		end
	end

endmodule

>>> rtl/ubxdf_back.sv
// ubxdf_back: walks a frame record field by field into the output register
// depends on ubxdf_pkg and ubxdf_field_if; fed by ubxdf_queue

module ubxdf_back import ubxdf_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  rec_req_t        head,
	output logic            pop,
	ubxdf_field_if.source   fields
);

	logic               valid_q;
	logic [4:0]         id_q;
	logic signed [32:0] value_q;
	logic               last_q;
	logic [2:0]         idx_q;

	logic               load;
	logic [4:0]         nid;
	logic signed [32:0] nval;
	logic               nlast;
	field_bytes_t       fb;

	assign fields.valid       = valid_q;
	assign fields.field_id    = id_q;
	assign fields.field_value = value_q;
	assign fields.last_field  = last_q;

	always_comb begin
		fb    = head.rec.fb;
		nid   = FID_FIX;
		nval  = '0;
		nlast = 1'b0;
		case (head.rec.kind)
			KIND_SOL: begin
				if (idx_q == 3'd0) begin
					nid  = FID_FIX;
					nval = zext33(32'(fb[16 - FIELD_BASE]));
				end else begin
					nid   = FID_SATS;
					nval  = zext33(32'(head.rec.sats));
					nlast = 1'b1;
				end
			end
			KIND_POSLLH: begin
				case (idx_q)
					3'd0: begin
						nid  = FID_LON;
						nval = sext33(le32_at(fb, 10 - FIELD_BASE));
					end
					3'd1: begin
						nid  = FID_LAT;
						nval = sext33(le32_at(fb, 14 - FIELD_BASE));
					end
					3'd2: begin
						nid  = FID_HEIGHT;
						nval = sext33(le32_at(fb, 22 - FIELD_BASE));
					end
					default: begin
						nid   = FID_HACC;
						nval  = zext33(le32_at(fb, 26 - FIELD_BASE));
						nlast = 1'b1;
					end
				endcase
			end
			KIND_VELNED: begin
				case (idx_q)
					3'd0: begin
						nid  = FID_VELN;
						nval = sext33(le32_at(fb, 10 - FIELD_BASE));
					end
					3'd1: begin
						nid  = FID_VELE;
						nval = sext33(le32_at(fb, 14 - FIELD_BASE));
					end
					3'd2: begin
						nid  = FID_VELD;
						nval = sext33(le32_at(fb, 18 - FIELD_BASE));
					end
					3'd3: begin
						nid  = FID_HEADING;
						nval = sext33(le32_at(fb, 30 - FIELD_BASE));
					end
					default: begin
						nid   = FID_SACC;
						nval  = zext33(le32_at(fb, 34 - FIELD_BASE));
						nlast = 1'b1;
					end
				endcase
			end
			default: begin
				case (idx_q)
					3'd0: begin
						nid  = FID_YEAR;
						nval = zext33({16'd0, fb[19 - FIELD_BASE], fb[18 - FIELD_BASE]});
					end
					3'd1: begin
						nid  = FID_MONTH;
						nval = zext33(32'(fb[20 - FIELD_BASE]));
					end
					3'd2: begin
						nid  = FID_DAY;
						nval = zext33(32'(fb[21 - FIELD_BASE]));
					end
					3'd3: begin
						nid  = FID_HOUR;
						nval = zext33(32'(fb[22 - FIELD_BASE]));
					end
					3'd4: begin
						nid  = FID_MINUTE;
						nval = zext33(32'(fb[23 - FIELD_BASE]));
					end
					default: begin
						nid   = FID_SECOND;
						nval  = zext33(32'(fb[24 - FIELD_BASE]));
						nlast = 1'b1;
					end
				endcase
			end
		endcase

		// output register frees up when empty or its word is taken
		load = head.valid && (!valid_q || fields.ready);
		pop  = load && nlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= nlast ? 3'd0 : idx_q + 3'd1;
			end else if (fields.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			id_q    <= nid;
			value_q <= nval;
			last_q  <= nlast;
		end
	end

endmodule

>>> rtl/ubx_frame_deframer.sv
// channel   dir  payload                                  handshake
// stream    in   data_byte[7:0]                           valid / ready
// fields    out  field_id[4:0] field_value[32:0] last     valid / ready
//
// one byte is taken every cycle; ready drops only when both queue entries hold frames
// a checked frame gives 2 to 6 field words, one per cycle out of the output register while fields ready is high
// a frame is at least 8 bytes, so the back end keeps pace with a full-rate byte stream
// asynchronous active-low reset returns to sync hunting with the byte store cleared
// a stalled output fills the two-entry queue before stream ready is pulled low
//
// top level of the deframer: front, queue and back
// depends on ubxdf_pkg, ubxdf_byte_if, ubxdf_field_if, ubxdf_front, ubxdf_queue, ubxdf_back

module ubx_frame_deframer import ubxdf_pkg::*; #(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ubxdf_byte_if.sink    stream,
	ubxdf_field_if.source fields
);

	rec_req_t push, head;
	logic     q_full, pop;

	ubxdf_front #(
		.MAX_FRAME (MAX_FRAME)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.q_full (q_full),
		.push   (push)
	);

	ubxdf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	ubxdf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.fields (fields)
	);

endmodule

>>> rtl/ubxdf_checker.sv
// ubxdf_checker: port-level checks on the field output of the deframer
// depends on ubxdf_pkg; bound to ubx_frame_deframer

module ubxdf_checker import ubxdf_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               f_valid,
	input logic               f_ready,
	input logic [4:0]         f_id,
	input logic signed [32:0] f_value,
	input logic               f_last
);

	logic       mid_q;
	logic [4:0] prev_id_q;
	logic       take;

	assign take = f_valid && f_ready;

	// tracks whether a frame's words are partly delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q     <= 1'b0;
			prev_id_q <= '0;
		end else if (take) begin
			mid_q     <= !f_last;
			prev_id_q <= f_id;
		end
	end

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !f_valid)
		else $error("field valid during reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid && !f_ready |=> f_valid && $stable(f_id) && $stable(f_value)
			&& $stable(f_last))
		else $error("field word changed while stalled");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		take && !mid_q |-> f_id == FID_FIX || f_id == FID_LON || f_id == FID_VELN
			|| f_id == FID_YEAR)
		else $error("frame starts on a wrong field");

	a_frame_seq: assert property (@(posedge clk) disable iff (!arst_n)
		take && mid_q |-> f_id == 5'(prev_id_q + 5'd1))
		else $error("field words out of order");

	a_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && f_last |-> f_id == FID_SATS || f_id == FID_HACC || f_id == FID_SACC
			|| f_id == FID_SECOND)
		else $error("last flag on a wrong field");

endmodule

bind ubx_frame_deframer ubxdf_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.f_valid (fields.valid),
	.f_ready (fields.ready),
	.f_id    (fields.field_id),
	.f_value (fields.field_value),
	.f_last  (fields.last_field)
);

>>> tb/ubx_frame_deframer_check.sv
`timescale 1ns / 100ps
// ubx_frame_deframer_check: watches the byte and field channels, predicts the field words
// of each frame and compares them in order; depends on ubxdf_pkg and the two channel interfaces

module ubx_frame_deframer_check import ubxdf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	ubxdf_byte_if  stream,
	ubxdf_field_if fields,
	output int     fail_count,
	output int     pending
);

	localparam int STORE_DEPTH = 64;
	localparam int MAX_FRAME   = MAX_FRAME_DEF;

	typedef struct packed {
		logic [4:0]         id;
		logic signed [32:0] value;
		logic               last;
	} field_word_t;

	logic [7:0]  frame_bytes [STORE_DEPTH];
	int unsigned frame_pos;
	logic [7:0]  run_a;
	logic [7:0]  run_b;
	logic [15:0] tail_pair;
	field_word_t expected_fields [$];
	field_word_t got;
	field_word_t want;

	function automatic logic signed [32:0] signed_word(int unsigned i);
		logic [31:0] v;
		v = {frame_bytes[i+3], frame_bytes[i+2], frame_bytes[i+1], frame_bytes[i]};
		return {v[31], v};
	endfunction

	function automatic logic signed [32:0] unsigned_word(int unsigned i);
		return {1'b0, frame_bytes[i+3], frame_bytes[i+2], frame_bytes[i+1], frame_bytes[i]};
	endfunction

	function automatic void push_field(logic [4:0] id, logic signed [32:0] value, logic last);
		field_word_t w;
		w.id = id;
		w.value = value;
		w.last = last;
		expected_fields.push_back(w);
	endfunction

	function automatic void emit_frame_fields();
		if (frame_bytes[2] != CLS_NAV)
			return;
		if (run_a != tail_pair[15:8] || run_b != tail_pair[7:0])
			return;
		case (frame_bytes[3])
			ID_SOL: begin
				push_field(FID_FIX, {25'd0, frame_bytes[16]}, 1'b0);
				push_field(FID_SATS, {25'd0, frame_bytes[SATS_POS]}, 1'b1);
			end
			ID_POSLLH: begin
				push_field(FID_LON, signed_word(10), 1'b0);
				push_field(FID_LAT, signed_word(14), 1'b0);
				push_field(FID_HEIGHT, signed_word(22), 1'b0);
				push_field(FID_HACC, unsigned_word(26), 1'b1);
			end
			ID_VELNED: begin
				push_field(FID_VELN, signed_word(10), 1'b0);
				push_field(FID_VELE, signed_word(14), 1'b0);
				push_field(FID_VELD, signed_word(18), 1'b0);
				push_field(FID_HEADING, signed_word(30), 1'b0);
				push_field(FID_SACC, unsigned_word(34), 1'b1);
			end
			ID_TIMEUTC: begin
				push_field(FID_YEAR, {17'd0, frame_bytes[19], frame_bytes[18]}, 1'b0);
				push_field(FID_MONTH, {25'd0, frame_bytes[20]}, 1'b0);
				push_field(FID_DAY, {25'd0, frame_bytes[21]}, 1'b0);
				push_field(FID_HOUR, {25'd0, frame_bytes[22]}, 1'b0);
				push_field(FID_MINUTE, {25'd0, frame_bytes[23]}, 1'b0);
				push_field(FID_SECOND, {25'd0, frame_bytes[24]}, 1'b1);
			end
			default: ;
		endcase
	endfunction

	function automatic void absorb_byte(logic [7:0] b);
		int unsigned total;
		if (frame_pos == 0) begin
			if (b == UBX_SYNC1) begin
				frame_bytes[0] = b;
				run_a = '0;
				run_b = '0;
				tail_pair = '0;
				frame_pos = 1;
			end
		end else if (frame_pos == 1) begin
			// a wrong second sync byte is not itself taken as a new first one
			if (b == UBX_SYNC2) begin
				frame_bytes[1] = b;
				frame_pos = 2;
			end else begin
				frame_pos = 0;
			end
		end else begin
			if (frame_pos < STORE_DEPTH)
				frame_bytes[frame_pos] = b;
			tail_pair = {tail_pair[7:0], b};
			total = LEN_EXTRA + {frame_bytes[5], frame_bytes[4]};
			// the two checksum bytes stay out of the running sum
			if (frame_pos < HDR_BYTES || frame_pos + 2 < total) begin
				run_a = run_a + b;
				run_b = run_b + run_a;
			end
			frame_pos++;
			if (frame_pos > HDR_BYTES && frame_pos >= total) begin
				emit_frame_fields();
				frame_pos = 0;
			end
			if (frame_pos >= MAX_FRAME)
				frame_pos = 0;
		end
	endfunction

	function automatic void report_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t check: %s", $time, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (frame_bytes[i])
				frame_bytes[i] = '0;
			frame_pos = 0;
			run_a = '0;
			run_b = '0;
			tail_pair = '0;
			expected_fields.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// byte first, so a word leaving at the same edge still finds its expectation
			if (stream.valid && stream.ready)
				absorb_byte(stream.data_byte);
			if (fields.valid && fields.ready) begin
				got = {fields.field_id, fields.field_value, fields.last_field};
				if (expected_fields.size() == 0) begin
					report_failure($sformatf("unexpected word id %0d value %0d last %0b",
						got.id, got.value, got.last));
				end else begin
					want = expected_fields.pop_front();
					if (got.id !== want.id || got.value !== want.value || got.last !== want.last)
						report_failure($sformatf(
							"expected id %0d value %0d last %0b, got id %0d value %0d last %0b",
							want.id, want.value, want.last, got.id, got.value, got.last));
				end
			end
			pending = expected_fields.size();
		end
	end

endmodule

>>> tb/ubx_frame_deframer_test.sv
`timescale 1ns / 100ps
// ubx_frame_deframer_test: builds byte streams of good, damaged and odd frames, drives them
// with random gaps and stalls, and gives the verdict; depends on the block and the checker

module ubx_frame_deframer_test;
	import ubxdf_pkg::*;

	localparam int FILL_RANDOM    = -1;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 60;
	localparam int LEN_POSLLH     = 28;
	localparam int LEN_RANDOM_MAX = 4;

	typedef enum int {CK_GOOD, CK_BAD_A, CK_BAD_B} sum_mode_e;

	logic       clk;
	logic       arst_n;
	int         src_idle_pct;
	int         sink_idle_pct;
	bit         hold_off_req;
	int         fail_count;
	int         pending;
	logic [7:0] tx_bytes [$];

	ubxdf_byte_if  stream ();
	ubxdf_field_if fields ();

	ubx_frame_deframer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.fields (fields)
	);

	ubx_frame_deframer_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.fields     (fields),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void add_frame(logic [7:0] cls, logic [7:0] mid, int len, int fill,
		sum_mode_e mode);
		logic [7:0] body [$];
		logic [7:0] ck_a;
		logic [7:0] ck_b;
		body = {cls, mid, 8'(len), 8'(len >> 8)};
		for (int i = 0; i < len; i++)
			body.push_back((fill == FILL_RANDOM) ? 8'($urandom) : 8'(fill));
		ck_a = '0;
		ck_b = '0;
		foreach (body[i]) begin
			ck_a = ck_a + body[i];
			ck_b = ck_b + ck_a;
		end
		if (mode == CK_BAD_A)
			ck_a = ck_a ^ 8'(1 << $urandom_range(7));
		if (mode == CK_BAD_B)
			ck_b = ck_b ^ 8'(1 << $urandom_range(7));
		tx_bytes.push_back(UBX_SYNC1);
		tx_bytes.push_back(UBX_SYNC2);
		foreach (body[i])
			tx_bytes.push_back(body[i]);
		tx_bytes.push_back(ck_a);
		tx_bytes.push_back(ck_b);
	endfunction

	function automatic void add_noise(int n);
		for (int i = 0; i < n; i++)
			tx_bytes.push_back(($urandom_range(3) == 0) ? UBX_SYNC1 : 8'($urandom));
	endfunction

	// returns 1 for a frame built to pass the checks
	function automatic bit add_random_frame();
		logic [7:0] ids [4];
		int         k;
		int         pick;
		int         len;
		logic [7:0] bad_byte;
		ids = '{ID_SOL, ID_POSLLH, ID_VELNED, ID_TIMEUTC};
		k = $urandom_range(3);
		pick = $urandom_range(99);
		// short frames keep the stream small and read what earlier frames left behind
		len = $urandom_range(LEN_RANDOM_MAX);
		if (pick < 70) begin
			add_frame(CLS_NAV, ids[k], len, FILL_RANDOM, CK_GOOD);
			return 1'b1;
		end
		if (pick < 80) begin
			add_frame(CLS_NAV, ids[k], len, FILL_RANDOM, $urandom_range(1) ? CK_BAD_A : CK_BAD_B);
		end else if (pick < 88) begin
			if ($urandom_range(1))
				add_frame(8'($urandom), ids[k], len, FILL_RANDOM, CK_GOOD);
			else
				add_frame(CLS_NAV, 8'($urandom), len, FILL_RANDOM, CK_GOOD);
		end else if (pick < 94) begin
			bad_byte = 8'($urandom);
			if (bad_byte == UBX_SYNC2)
				bad_byte = UBX_SYNC1;
			tx_bytes.push_back(UBX_SYNC1);
			tx_bytes.push_back(bad_byte);
		end else begin
			add_noise($urandom_range(6, 1));
		end
		return 1'b0;
	endfunction

	function automatic void add_directed();
		add_frame(CLS_NAV, ID_POSLLH, LEN_POSLLH, FILL_RANDOM, CK_GOOD);
		// short frames read whatever earlier frames left behind
		add_frame(CLS_NAV, ID_VELNED, 0, FILL_RANDOM, CK_GOOD);
		// broken sync: wrong second byte, then a doubled first sync byte
		tx_bytes.push_back(UBX_SYNC1);
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(UBX_SYNC1);
		add_frame(CLS_NAV, ID_SOL, 0, FILL_RANDOM, CK_GOOD);
		add_frame(CLS_NAV, ID_TIMEUTC, 0, FILL_RANDOM, CK_BAD_B);
		add_frame(CLS_NAV, ID_TIMEUTC, 2, FILL_RANDOM, CK_GOOD);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			stream.valid <= 1'b0;
			@(posedge clk);
		end
		stream.valid <= 1'b1;
		stream.data_byte <= b;
		// ready is stable between the falling edge and the next rising edge
		@(negedge clk);
		while (!stream.ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_pending();
		while (tx_bytes.size() > 0)
			send_byte(tx_bytes.pop_front());
	endtask

	task automatic wait_drained();
		stream.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic run_random(input int src_pct, input int sink_pct, input int frames);
		int made;
		made = 0;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		while (made < frames) begin
			if (add_random_frame())
				made++;
			send_pending();
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		fields.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				fields.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			fields.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		stream.valid = 1'b0;
		stream.data_byte = '0;
		hold_off_req = 1'b0;
		src_idle_pct = 28;
		sink_idle_pct = 62;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_directed();
		send_pending();

		// stall the output long enough for the frame queue to fill and hold the input
		hold_off_req = 1'b1;
		add_frame(CLS_NAV, ID_TIMEUTC, 0, FILL_RANDOM, CK_GOOD);
		add_frame(CLS_NAV, ID_POSLLH, 0, FILL_RANDOM, CK_GOOD);
		add_frame(CLS_NAV, ID_VELNED, 0, FILL_RANDOM, CK_GOOD);
		send_pending();
		wait_drained();

		run_random(62, 28, 1);
		run_random(0, 0, 1);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
